// File: hw/rtl/bqlim_pkg.sv
// Shared types and constants of the biquad filter with output limiter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bqlim_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned SHORT_W   = 16;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned Y_W       = 40;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned REG_IDX_W = 3;

  // taps of the difference equation
  localparam int unsigned TAPS   = 5;
  localparam int unsigned TAP_B0 = 0;
  localparam int unsigned TAP_B1 = 1;
  localparam int unsigned TAP_B2 = 2;
  localparam int unsigned TAP_A1 = 3;
  localparam int unsigned TAP_A2 = 4;

  // operand split for the partial products
  localparam int unsigned SPLIT_W = 20;
  localparam int unsigned PROD_W  = COEF_W + Y_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic signed [Y_W-1:0] LIMIT_16 = 40'sd32767;
  localparam logic signed [Y_W-1:0] LIMIT_32 = 40'sd2147462173;

  localparam logic [COEF_W-1:0] COEF_ONE = 32'h1000_0000;

  localparam logic [MODE_W-1:0] MODE_BYPASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE_POLE = 2'd1;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B0       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B1       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B2       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A1       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A2       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_MASK  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd7;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_CLAMP,
    KIND_ONE_POLE,
    KIND_BIQUAD
  } kind_e;

  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic [TAPS-1:0][COEF_W-1:0]  coef;
    logic [MASK_W-1:0]            mask;
    logic                         wide;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    kind_e               kind;
    logic                wide;
    logic [SAMPLE_W-1:0] x;
  } op_t;

endpackage

`default_nettype wire

// File: hw/rtl/bqlim_front.sv
// Input side: normalizes the sample and classifies the word by channel and mode.
// Depends on bqlim_pkg.
`default_nettype none

module bqlim_front #(
  parameter int CHANNELS = 8
) (
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [bqlim_pkg::CH_W-1:0]     channel_i,
  input  logic [bqlim_pkg::SAMPLE_W-1:0] sample_i,
  input  bqlim_pkg::cfg_t                cfg_i,
  input  logic                           full_i,
  output logic                           push_o,
  output bqlim_pkg::op_t                 op_o
);

  logic enabled;

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;
  assign enabled   = (int'(channel_i) < CHANNELS) && cfg_i.mask[channel_i];

  always_comb begin
    op_o.channel = channel_i;
    op_o.wide    = cfg_i.wide;
    op_o.x       = cfg_i.wide ? sample_i
                 : {{(bqlim_pkg::SAMPLE_W - bqlim_pkg::SHORT_W){sample_i[bqlim_pkg::SHORT_W-1]}},
                    sample_i[bqlim_pkg::SHORT_W-1:0]};
    if (!enabled) begin
      op_o.kind = bqlim_pkg::KIND_PASS;
    end else begin
      unique case (cfg_i.mode)
        bqlim_pkg::MODE_BYPASS:   op_o.kind = bqlim_pkg::KIND_CLAMP;
        bqlim_pkg::MODE_ONE_POLE: op_o.kind = bqlim_pkg::KIND_ONE_POLE;
        default:                  op_o.kind = bqlim_pkg::KIND_BIQUAD;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bqlim_queue.sv
// Two-entry queue of classified words between the front and back sides.
// Depends on bqlim_pkg.
`default_nettype none

module bqlim_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bqlim_pkg::op_t op_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output bqlim_pkg::op_t op_o
);

  bqlim_pkg::op_t                    mem_q [bqlim_pkg::QUEUE_DEPTH];
  logic [bqlim_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [bqlim_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [bqlim_pkg::QCNT_W-1:0]      count_q, count_d;

  assign full_o  = (count_q == bqlim_pkg::QCNT_W'(bqlim_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && full_o))
    else $error("queue push while full");

endmodule

`default_nettype wire

// File: hw/rtl/bqlim_back.sv
// Back side: per-channel delay lines, split coefficient products, accumulate with
// saturation, write-back, and the limiting output register. Depends on bqlim_pkg.
`default_nettype none

module bqlim_back #(
  parameter int CHANNELS       = 8,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  bqlim_pkg::op_t                 head_i,
  output logic                           pop_o,
  input  bqlim_pkg::cfg_t                cfg_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [bqlim_pkg::CH_W-1:0]     m_channel_o,
  output logic [bqlim_pkg::SAMPLE_W-1:0] m_sample_o
);

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LO_W   = bqlim_pkg::SPLIT_W;
  localparam int HI_W   = bqlim_pkg::Y_W - bqlim_pkg::SPLIT_W;
  localparam int PL_W   = bqlim_pkg::COEF_W + LO_W + 1;
  localparam int PH_W   = bqlim_pkg::COEF_W + HI_W;
  localparam int PROD_W = bqlim_pkg::PROD_W;
  localparam int TERM_W = PROD_W - COEF_FRAC_BITS;
  localparam int SUM_W  = TERM_W + 3;
  localparam int Y_W    = bqlim_pkg::Y_W;
  localparam int S_W    = bqlim_pkg::SAMPLE_W;
  localparam int TAPS   = bqlim_pkg::TAPS;

  typedef struct packed {
    logic [bqlim_pkg::CH_W-1:0] channel;
    bqlim_pkg::kind_e           kind;
    logic                       wide;
    logic signed [S_W-1:0]      x;
    logic signed [S_W-1:0]      x1;
    logic signed [Y_W-1:0]      y1;
  } stage_t;

  typedef struct packed {
    logic [bqlim_pkg::CH_W-1:0] channel;
    logic                       pass;
    logic                       wide;
    logic signed [Y_W-1:0]      y;
  } out_t;

  // per-channel delay lines
  logic signed [S_W-1:0] x1_q [CHANNELS];
  logic signed [S_W-1:0] x2_q [CHANNELS];
  logic signed [Y_W-1:0] y1_q [CHANNELS];
  logic signed [Y_W-1:0] y2_q [CHANNELS];

  logic                  head_filt;
  logic                  head_biq;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      wr_idx;
  logic signed [Y_W-1:0] opnd [TAPS];

  logic                  a_valid_q, a_valid_d;
  stage_t                a_q, a_d;
  logic signed [PL_W-1:0] pl_q [TAPS];
  logic signed [PL_W-1:0] pl_d [TAPS];
  logic signed [PH_W-1:0] ph_q [TAPS];
  logic signed [PH_W-1:0] ph_d [TAPS];
  logic signed [TERM_W-1:0] term [TAPS];

  logic signed [SUM_W-1:0]       sum;
  logic [SUM_W-Y_W:0]            hi_bits;
  logic signed [Y_W-1:0]         y_filt;
  logic signed [Y_W-1:0]         y_new;
  logic                          a_filt;
  logic                          a_adv;

  logic                  o_valid_q, o_valid_d;
  out_t                  o_q, o_d;
  logic signed [Y_W-1:0] lim;
  logic signed [Y_W-1:0] y_lim;

  // issue: one word at a time through the read-modify-write of the delay lines
  assign pop_o     = head_valid_i && !a_valid_q;
  assign head_filt = (head_i.kind == bqlim_pkg::KIND_ONE_POLE) ||
                     (head_i.kind == bqlim_pkg::KIND_BIQUAD);
  assign head_biq  = (head_i.kind == bqlim_pkg::KIND_BIQUAD);
  assign rd_idx    = head_filt ? IDX_W'(head_i.channel) : '0;

  always_comb begin
    opnd[bqlim_pkg::TAP_B0] = Y_W'(signed'(head_i.x));
    opnd[bqlim_pkg::TAP_B1] = head_biq ? Y_W'(x1_q[rd_idx]) : '0;
    opnd[bqlim_pkg::TAP_B2] = head_biq ? Y_W'(x2_q[rd_idx]) : '0;
    opnd[bqlim_pkg::TAP_A1] = y1_q[rd_idx];
    opnd[bqlim_pkg::TAP_A2] = head_biq ? y2_q[rd_idx] : '0;
  end

  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    logic signed [bqlim_pkg::COEF_W-1:0] c;
    logic signed [LO_W:0]                lo;
    logic signed [HI_W-1:0]              hi;
    logic signed [PROD_W-1:0]            full;

    assign c       = signed'(cfg_i.coef[t]);
    assign lo      = signed'({1'b0, opnd[t][LO_W-1:0]});
    assign hi      = opnd[t][Y_W-1:LO_W];
    assign pl_d[t] = c * lo;
    assign ph_d[t] = c * hi;

    // rejoin the partial products, then floor to the sample grid
    assign full    = (PROD_W'(ph_q[t]) <<< LO_W) + PROD_W'(pl_q[t]);
    assign term[t] = TERM_W'(full >>> COEF_FRAC_BITS);
  end

  always_comb begin
    a_d.channel = head_i.channel;
    a_d.kind    = head_i.kind;
    a_d.wide    = head_i.wide;
    a_d.x       = signed'(head_i.x);
    a_d.x1      = x1_q[rd_idx];
    a_d.y1      = y1_q[rd_idx];
  end

  // accumulate and saturate
  always_comb begin
    sum = SUM_W'(term[bqlim_pkg::TAP_B0]) + SUM_W'(term[bqlim_pkg::TAP_B1])
        + SUM_W'(term[bqlim_pkg::TAP_B2]);
    if (a_q.kind == bqlim_pkg::KIND_BIQUAD) begin
      sum = sum - SUM_W'(term[bqlim_pkg::TAP_A1]) - SUM_W'(term[bqlim_pkg::TAP_A2]);
    end else begin
      sum = sum + SUM_W'(term[bqlim_pkg::TAP_A1]) + SUM_W'(term[bqlim_pkg::TAP_A2]);
    end
    hi_bits = sum[SUM_W-1:Y_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      y_filt = sum[Y_W-1:0];
    end else if (sum[SUM_W-1]) begin
      y_filt = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_filt = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  assign a_filt = (a_q.kind == bqlim_pkg::KIND_ONE_POLE) ||
                  (a_q.kind == bqlim_pkg::KIND_BIQUAD);
  assign y_new  = a_filt ? y_filt : Y_W'(a_q.x);
  assign wr_idx = IDX_W'(a_q.channel);
  assign a_adv  = a_valid_q && (!o_valid_q || m_ready_i);

  always_comb begin
    a_valid_d = a_valid_q;
    if (pop_o) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q  <= a_d;
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
  end

  // write back the delay lines as the word leaves the accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '{default: '0};
      x2_q <= '{default: '0};
      y1_q <= '{default: '0};
      y2_q <= '{default: '0};
    end else if (a_adv) begin
      if (a_q.kind == bqlim_pkg::KIND_ONE_POLE) begin
        y1_q[wr_idx] <= y_new;
      end else if (a_q.kind == bqlim_pkg::KIND_BIQUAD) begin
        x2_q[wr_idx] <= a_q.x1;
        x1_q[wr_idx] <= a_q.x;
        y2_q[wr_idx] <= a_q.y1;
        y1_q[wr_idx] <= y_new;
      end
    end
  end

  // output register
  always_comb begin
    o_d.channel = a_q.channel;
    o_d.pass    = (a_q.kind == bqlim_pkg::KIND_PASS);
    o_d.wide    = a_q.wide;
    o_d.y       = y_new;
    o_valid_d   = o_valid_q;
    if (a_adv) begin
      o_valid_d = 1'b1;
    end else if (m_ready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      o_q <= o_d;
    end
  end

  // symmetric limiter
  assign lim = o_q.wide ? bqlim_pkg::LIMIT_32 : bqlim_pkg::LIMIT_16;

  always_comb begin
    y_lim = o_q.y;
    if (!o_q.pass) begin
      if (o_q.y > lim) begin
        y_lim = lim;
      end else if (o_q.y < -lim) begin
        y_lim = -lim;
      end
    end
  end

  assign m_valid_o   = o_valid_q;
  assign m_channel_o = o_q.channel;
  assign m_sample_o  = y_lim[S_W-1:0];

  a_rmw_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |=> !a_valid_q)
    else $error("word issued before delay line write-back");

  a_issue_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> a_valid_q)
    else $error("popped word lost before accumulate stage");

  a_limit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !o_q.pass) |-> ((y_lim <= lim) && (y_lim >= -lim)))
    else $error("limited sample out of range");

endmodule

`default_nettype wire

// File: hw/rtl/biquad_filter_with_limiter.sv
// Multichannel biquad / one-pole filter with symmetric output limiter.
// Input words carry a PCM sample in tdata and its channel number in tuser.
// Configuration is a plain write port: cfg_we_i, cfg_addr_i, cfg_wdata_i; write
// only while no word is in flight.
// The delay lines take one word at a time through their per-channel read-modify-write:
// the split products are registered, then the word is accumulated and written back
// before the next issues. Results pass the queue, product and output registers.
// A two-entry queue sits between input classification and the filter datapath,
// and the result waits in an output register, so input keeps flowing while
// the receiver holds tready low until the queue fills; then s_axis_tready drops.
// Reset: configuration returns to bypass, b0 = 1.0, all channels enabled,
// 16-bit format; all delay lines clear; no words in flight.
// Depends on bqlim_pkg, bqlim_front, bqlim_queue, bqlim_back.
`default_nettype none

module biquad_filter_with_limiter #(
  parameter int CHANNELS       = 8,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bqlim_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] in_sample
  input  logic [bqlim_pkg::CH_W-1:0]      s_axis_tuser,   // [2:0] channel_index
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bqlim_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [31:0] out_sample
  output logic [bqlim_pkg::CH_W-1:0]      m_axis_tuser,   // [2:0] out_channel
  input  logic                            cfg_we_i,
  input  logic [bqlim_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  logic [bqlim_pkg::COEF_W-1:0]    cfg_wdata_i
);

  localparam logic [bqlim_pkg::TAPS-1:0][bqlim_pkg::COEF_W-1:0] COEF_RESET =
    {{((bqlim_pkg::TAPS - 1) * bqlim_pkg::COEF_W){1'b0}}, bqlim_pkg::COEF_ONE}
      << (bqlim_pkg::TAP_B0 * bqlim_pkg::COEF_W);

  bqlim_pkg::cfg_t cfg_q, cfg_d;
  bqlim_pkg::op_t  front_op;
  bqlim_pkg::op_t  head_op;
  logic            push;
  logic            pop;
  logic            full;
  logic            head_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bqlim_pkg::REG_FILTER_MODE:   cfg_d.mode = cfg_wdata_i[bqlim_pkg::MODE_W-1:0];
        bqlim_pkg::REG_COEF_B0:       cfg_d.coef[bqlim_pkg::TAP_B0] = cfg_wdata_i;
        bqlim_pkg::REG_COEF_B1:       cfg_d.coef[bqlim_pkg::TAP_B1] = cfg_wdata_i;
        bqlim_pkg::REG_COEF_B2:       cfg_d.coef[bqlim_pkg::TAP_B2] = cfg_wdata_i;
        bqlim_pkg::REG_COEF_A1:       cfg_d.coef[bqlim_pkg::TAP_A1] = cfg_wdata_i;
        bqlim_pkg::REG_COEF_A2:       cfg_d.coef[bqlim_pkg::TAP_A2] = cfg_wdata_i;
        bqlim_pkg::REG_CHANNEL_MASK:  cfg_d.mask = cfg_wdata_i[bqlim_pkg::MASK_W-1:0];
        bqlim_pkg::REG_SAMPLE_FORMAT: cfg_d.wide = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode                      <= bqlim_pkg::MODE_BYPASS;
      cfg_q.coef                      <= COEF_RESET;
      cfg_q.mask                      <= '1;
      cfg_q.wide                      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bqlim_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .channel_i (s_axis_tuser),
    .sample_i  (s_axis_tdata),
    .cfg_i     (cfg_q),
    .full_i    (full),
    .push_o    (push),
    .op_o      (front_op)
  );

  bqlim_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .op_o    (head_op)
  );

  bqlim_back #(
    .CHANNELS       (CHANNELS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_op),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_channel_o  (m_axis_tuser),
    .m_sample_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire
